### sv/lsst_pkg.sv
// Shared constants, codes and types of the level-segmented sorted table.
`default_nettype none
package lsst_pkg;

	// sizing
	localparam int unsigned CAPACITY   = 4096;
	localparam int unsigned MAX_LEVELS = 16;
	localparam int unsigned KEY_BITS   = 32;

	localparam int unsigned IDX_W  = $clog2(CAPACITY);
	localparam int unsigned CNT_W  = IDX_W + 1;
	localparam int unsigned LVL_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int unsigned BIDX_W = $clog2(MAX_LEVELS + 1);
	localparam int unsigned TOP_MAX = MAX_LEVELS - 1;

	// port field widths
	localparam int unsigned OP_W     = 2;
	localparam int unsigned LEVEL_W  = 4;
	localparam int unsigned KEY_W    = 32;
	localparam int unsigned SLOT_W   = 12;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned POS_W    = 12;
	localparam int unsigned CFG_W    = 4;

	localparam int unsigned S_DATA_W = 48;
	localparam int unsigned M_DATA_W = 24;

	localparam logic [CFG_W-1:0] TOP_RESET = 4'd15;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_FIND   = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_LEVEL = 2'd3;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [SLOT_W-1:0]   slot;
	} entry_t;

	typedef struct packed {
		logic             re;
		logic [IDX_W-1:0] raddr;
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
	} mem_req_t;

	typedef struct packed {
		logic              inc;
		logic              dec;
		logic [LVL_W-1:0]  lvl;
		logic [LVL_W-1:0]  top;
		logic [BIDX_W-1:0] ridx;
	} bnd_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot_out;
		logic [POS_W-1:0]    position;
	} result_t;

endpackage
`default_nettype wire

### sv/lsst_mem.sv
// Entry store: one write port, one read port, registered read data.
`default_nettype none
module lsst_mem (
	input  wire logic              clk,
	input  wire lsst_pkg::mem_req_t req,
	output lsst_pkg::entry_t       rdata
);
	import lsst_pkg::*;

	entry_t mem_q [CAPACITY];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rd_q;

endmodule
`default_nettype wire

### sv/lsst_bounds.sv
// Level boundary registers: one read index, saturating bulk increment/decrement.
`default_nettype none
module lsst_bounds (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire lsst_pkg::bnd_cmd_t       cmd,
	output logic [lsst_pkg::CNT_W-1:0]    rdata
);
	import lsst_pkg::*;

	logic [CNT_W-1:0] bnd_q [MAX_LEVELS+1];

	assign rdata = bnd_q[cmd.ridx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= int'(MAX_LEVELS); j++) begin
				bnd_q[j] <= '0;
			end
		end else begin
			for (int j = 0; j <= int'(MAX_LEVELS); j++) begin
				if (j > int'(cmd.lvl) && j <= int'(cmd.top) + 1) begin
					if (cmd.inc && bnd_q[j] < CNT_W'(CAPACITY)) begin
						bnd_q[j] <= bnd_q[j] + CNT_W'(1);
					end else if (cmd.dec && bnd_q[j] != '0) begin
						bnd_q[j] <= bnd_q[j] - CNT_W'(1);
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

### sv/lsst_ctrl.sv
// Operation sequencer: boundary fetch, segment scan, entry shift, insert write, result.
`default_nettype none
module lsst_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [lsst_pkg::OP_W-1:0]     operation,
	input  wire logic [lsst_pkg::LEVEL_W-1:0]  level,
	input  wire logic [lsst_pkg::KEY_W-1:0]    key,
	input  wire logic [lsst_pkg::SLOT_W-1:0]   slot,
	input  wire logic [lsst_pkg::LVL_W-1:0]    top_eff,
	input  wire lsst_pkg::entry_t              mem_rdata,
	output lsst_pkg::mem_req_t                 mem_req,
	input  wire logic [lsst_pkg::CNT_W-1:0]    bnd_rdata,
	output lsst_pkg::bnd_cmd_t                 bnd_cmd,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output lsst_pkg::result_t                  res
);
	import lsst_pkg::*;

	typedef enum logic [2:0] {
		IDLE, RD_TOT, RD_END, RD_START, SCAN, SHIFT, PUT, FIN
	} state_t;

	state_t              state_q;
	logic [OP_W-1:0]     op_q;
	logic [LVL_W-1:0]    lvl_q;
	logic [LVL_W-1:0]    top_q;
	logic [KEY_BITS-1:0] key_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [CNT_W-1:0]    total_q;
	logic [CNT_W-1:0]    e_q;
	logic [CNT_W-1:0]    a_q;
	logic                v_s1;
	logic [CNT_W-1:0]    idx_s1;
	logic [CNT_W-1:0]    i_q;
	logic [CNT_W-1:0]    n_q;
	logic [CNT_W-1:0]    r_q;
	logic                up_q;
	logic                wv_s1;
	logic [IDX_W-1:0]    waddr_s1;
	logic                inc_q;
	logic                dec_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   slot_out_q;

	logic             issue;
	logic             hit;
	logic [CNT_W-1:0] pos;
	logic [CNT_W-1:0] s_clamp;
	logic [CNT_W-1:0] r_inc;
	logic [CNT_W-1:0] r_dec;

	assign issue   = (a_q < e_q);
	assign hit     = v_s1 && ((op_q == OP_INSERT) ? (key_q > mem_rdata.key)
	                                               : (key_q == mem_rdata.key));
	assign pos     = hit ? idx_s1 : e_q;
	assign s_clamp = (bnd_rdata > e_q) ? e_q : bnd_rdata;
	assign r_inc   = r_q + CNT_W'(1);
	assign r_dec   = r_q - CNT_W'(1);

	assign in_ready  = (state_q == IDLE);
	assign res_valid = (state_q == FIN);
	assign res.status   = status_q;
	assign res.slot_out = slot_out_q;
	assign res.position = POS_W'(i_q);

	always_comb begin
		mem_req       = '0;
		bnd_cmd.lvl   = lvl_q;
		bnd_cmd.top   = top_q;
		bnd_cmd.inc   = 1'b0;
		bnd_cmd.dec   = 1'b0;
		bnd_cmd.ridx  = BIDX_W'(lvl_q);
		case (state_q)
			RD_TOT: bnd_cmd.ridx = BIDX_W'(top_q) + BIDX_W'(1);
			RD_END: bnd_cmd.ridx = BIDX_W'(lvl_q) + BIDX_W'(1);
			SCAN: begin
				mem_req.re    = issue;
				mem_req.raddr = a_q[IDX_W-1:0];
			end
			SHIFT: begin
				mem_req.re    = (n_q != '0);
				mem_req.raddr = r_q[IDX_W-1:0];
				mem_req.we    = wv_s1;
				mem_req.waddr = waddr_s1;
				mem_req.wdata = mem_rdata;
			end
			PUT: begin
				mem_req.we         = 1'b1;
				mem_req.waddr      = i_q[IDX_W-1:0];
				mem_req.wdata.key  = key_q;
				mem_req.wdata.slot = slot_q;
			end
			FIN: begin
				bnd_cmd.inc = inc_q && res_ready;
				bnd_cmd.dec = dec_q && res_ready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			v_s1       <= 1'b0;
			wv_s1      <= 1'b0;
			inc_q      <= 1'b0;
			dec_q      <= 1'b0;
			op_q       <= OP_NONE;
			lvl_q      <= '0;
			top_q      <= '0;
			key_q      <= '0;
			slot_q     <= '0;
			total_q    <= '0;
			e_q        <= '0;
			a_q        <= '0;
			idx_s1     <= '0;
			i_q        <= '0;
			n_q        <= '0;
			r_q        <= '0;
			up_q       <= 1'b0;
			waddr_s1   <= '0;
			status_q   <= ST_DONE;
			slot_out_q <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (in_valid) begin
						op_q       <= operation;
						lvl_q      <= LVL_W'(level);
						top_q      <= top_eff;
						key_q      <= KEY_BITS'(key);
						slot_q     <= slot;
						inc_q      <= 1'b0;
						dec_q      <= 1'b0;
						status_q   <= ST_DONE;
						slot_out_q <= '0;
						i_q        <= '0;
						if (operation == OP_NONE) begin
							state_q <= FIN;
						end else if (int'(level) > int'(top_eff)) begin
							status_q <= ST_BAD_LEVEL;
							state_q  <= FIN;
						end else begin
							state_q <= RD_TOT;
						end
					end
				end
				RD_TOT: begin
					total_q <= (bnd_rdata > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : bnd_rdata;
					state_q <= RD_END;
				end
				RD_END: begin
					e_q     <= (bnd_rdata > total_q) ? total_q : bnd_rdata;
					state_q <= RD_START;
				end
				RD_START: begin
					a_q  <= s_clamp;
					v_s1 <= 1'b0;
					if (op_q == OP_INSERT && total_q >= CNT_W'(CAPACITY)) begin
						status_q <= ST_FULL;
						state_q  <= FIN;
					end else begin
						state_q <= SCAN;
					end
				end
				SCAN: begin
					if (issue) begin
						a_q    <= a_q + CNT_W'(1);
						idx_s1 <= a_q;
						v_s1   <= 1'b1;
					end else begin
						v_s1 <= 1'b0;
					end
					if (hit || !issue) begin
						v_s1  <= 1'b0;
						wv_s1 <= 1'b0;
						if (op_q == OP_INSERT) begin
							// open a hole at pos by moving [pos, total) up one
							i_q     <= pos;
							n_q     <= total_q - pos;
							r_q     <= total_q - CNT_W'(1);
							up_q    <= 1'b1;
							inc_q   <= 1'b1;
							state_q <= SHIFT;
						end else if (!hit) begin
							status_q <= ST_NOT_FOUND;
							state_q  <= FIN;
						end else if (op_q == OP_FIND) begin
							i_q        <= idx_s1;
							slot_out_q <= mem_rdata.slot;
							state_q    <= FIN;
						end else begin
							// close the gap: move (pos, total) down one
							i_q     <= idx_s1;
							n_q     <= total_q - idx_s1 - CNT_W'(1);
							r_q     <= idx_s1 + CNT_W'(1);
							up_q    <= 1'b0;
							dec_q   <= 1'b1;
							state_q <= SHIFT;
						end
					end
				end
				SHIFT: begin
					if (n_q != '0) begin
						n_q      <= n_q - CNT_W'(1);
						r_q      <= up_q ? r_dec : r_inc;
						waddr_s1 <= up_q ? r_inc[IDX_W-1:0] : r_dec[IDX_W-1:0];
						wv_s1    <= 1'b1;
					end else begin
						wv_s1 <= 1'b0;
						if (!wv_s1) begin
							state_q <= up_q ? PUT : FIN;
						end
					end
				end
				PUT: begin
					state_q <= FIN;
				end
				FIN: begin
					if (res_ready) begin
						inc_q   <= 1'b0;
						dec_q   <= 1'b0;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### sv/level_segmented_sorted_table_top.sv
// Top level of the level-segmented sorted table: ports, config register, result register.
//
// Usage: a sorted (key, slot) table split into one segment per level, keys
// descending inside a segment. Commands arrive on the s_axis channel
// (tuser = operation; tdata = level, key, slot), one status/result
// transaction per command leaves on m_axis (tuser = status; tdata =
// slot_out, position). The cfg channel writes top_level; the user must keep
// to writing it while idle, which the block itself does not enforce. One
// command is processed at a time. A command runs three boundary reads, a
// pipelined scan of the segment (one entry per cycle), then for
// insert/delete a shift of every later entry (one per cycle) and for insert
// one more write. Both the scan and the shift are paced by the single read
// port of the entry memory. Find and failed lookups take no shift.
// Reset clears all level boundaries (empty table) and sets top_level to
// 15; the entry memory needs no clearing. The result sits in an output
// register, so the next command is taken while it waits; a further result
// is held back until m_axis_tready takes the previous one.
`default_nettype none
module level_segmented_sorted_table_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [lsst_pkg::S_DATA_W-1:0]   s_axis_tdata,  // level[3:0], key[35:4], slot[47:36]
	input  wire logic [lsst_pkg::OP_W-1:0]       s_axis_tuser,  // operation[1:0]
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [lsst_pkg::M_DATA_W-1:0]        m_axis_tdata,  // slot_out[11:0], position[23:12]
	output logic [lsst_pkg::STATUS_W-1:0]        m_axis_tuser,  // status[1:0]
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [lsst_pkg::CFG_W-1:0]      cfg_data       // top_level[3:0]
);
	import lsst_pkg::*;

	logic [CFG_W-1:0] top_level_q;
	logic [LVL_W-1:0] top_eff;

	mem_req_t         mem_req;
	entry_t           mem_rdata;
	bnd_cmd_t         bnd_cmd;
	logic [CNT_W-1:0] bnd_rdata;

	logic    res_valid;
	logic    res_ready;
	result_t res;

	logic    m_valid_q;
	result_t m_res_q;

	// config: always ready, register applies to the next command
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_level_q <= TOP_RESET;
		end else if (cfg_valid) begin
			top_level_q <= cfg_data;
		end
	end

	// top level beyond the supported level count saturates
	assign top_eff = (int'(top_level_q) > int'(TOP_MAX)) ? LVL_W'(TOP_MAX)
	                                                     : LVL_W'(top_level_q);

	lsst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.operation (s_axis_tuser),
		.level     (s_axis_tdata[3:0]),
		.key       (s_axis_tdata[35:4]),
		.slot      (s_axis_tdata[47:36]),
		.top_eff   (top_eff),
		.mem_rdata (mem_rdata),
		.mem_req   (mem_req),
		.bnd_rdata (bnd_rdata),
		.bnd_cmd   (bnd_cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	lsst_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	lsst_bounds u_bounds (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (bnd_cmd),
		.rdata  (bnd_rdata)
	);

	// output register: frees the sequencer as soon as the result is parked
	assign res_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			m_res_q   <= '0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
			if (res_valid) begin
				m_res_q <= res;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_res_q.status;
	assign m_axis_tdata  = {m_res_q.position, m_res_q.slot_out};

	// shift traffic never reads and writes the same entry in one cycle
	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
		else $error("entry memory read and write hit the same address");

	// a failed command reports zero slot and position
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != ST_DONE) |-> (m_axis_tdata == '0))
		else $error("non-zero payload with failure status");

	// one command at a time: after a command transaction the input closes
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("command taken while another is in progress");

	// boundaries only move on the cycle a result is handed over
	a_bnd_move: assert property (@(posedge clk) disable iff (!arst_n)
		(bnd_cmd.inc || bnd_cmd.dec) |-> (res_valid && res_ready && !(bnd_cmd.inc && bnd_cmd.dec)))
		else $error("boundary update outside result handover");

endmodule
`default_nettype wire
